// ----- rtl/apip_pkg.sv -----
// ----------------------------------------------------------------------------
// apip_pkg
// shared types and constants of the affine point-in-primitive clip test
// ----------------------------------------------------------------------------
package apip_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH      = 16;
  localparam int COEF_FRAC       = 12;
  localparam int LOC_FRAC        = 20;
  localparam int SQ_WIDTH        = 2 * LOC_FRAC;
  localparam int CFG_ADDR_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int SHAPE_WIDTH     = 3;
  localparam int NUM_AXES        = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SHAPE = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW_X = 2'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW_Y = 2'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW_Z = 2'd3;

  // primitive codes
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_PLANE    = 3'd0;
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_BOX      = 3'd1;
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_SPHERE   = 3'd2;
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_CYLINDER = 3'd3;
  localparam logic [SHAPE_WIDTH-1:0] SHAPE_CONE     = 3'd4;

  // one matrix row: translation q8.8 on top, q4.12 coefficients below
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] tr;
    logic signed [COEF_WIDTH-1:0] cz;
    logic signed [COEF_WIDTH-1:0] cy;
    logic signed [COEF_WIDTH-1:0] cx;
  } row_t;

  localparam row_t ROW_X_RST = 64'h0000_0000_0000_1000;
  localparam row_t ROW_Y_RST = 64'h0000_0000_1000_0000;
  localparam row_t ROW_Z_RST = 64'h0000_1000_0000_0000;

  // flags of one point after the range checks
  typedef struct packed {
    logic ok_x;
    logic ok_y;
    logic ok_z;
    logic y_in;
    logic z_pos;
  } range_t;

  function automatic int loc_width(input int cw);
    int pw;
    pw = cw + COEF_WIDTH;
    return ((pw > COEF_WIDTH + COEF_FRAC) ? pw : COEF_WIDTH + COEF_FRAC) + 2;
  endfunction

endpackage

// ----- rtl/apip_map.sv -----
// ----------------------------------------------------------------------------
// apip_map
// affine mapping of a point into the primitive frame, multiply and sum stages
// ----------------------------------------------------------------------------
module apip_map #(
  parameter int COORD_WIDTH = apip_pkg::COORD_WIDTH_DEF,
  parameter int LOC_WIDTH   = apip_pkg::loc_width(apip_pkg::COORD_WIDTH_DEF)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] pz,
  input  apip_pkg::row_t              row_x,
  input  apip_pkg::row_t              row_y,
  input  apip_pkg::row_t              row_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [LOC_WIDTH-1:0] lx,
  output logic signed [LOC_WIDTH-1:0] ly,
  output logic signed [LOC_WIDTH-1:0] lz
);
  import apip_pkg::*;

  localparam int PW = COORD_WIDTH + COEF_WIDTH;
  localparam int TW = COEF_WIDTH + COEF_FRAC;

  row_t                      rows [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] pts [NUM_AXES];
  logic signed [PW-1:0]      prod_r [NUM_AXES][NUM_AXES];
  logic signed [LOC_WIDTH-1:0] loc_r [NUM_AXES];
  logic signed [LOC_WIDTH-1:0] loc_nxt [NUM_AXES];
  logic                      v1_r;
  logic                      v2_r;
  logic                      en1;
  logic                      en2;

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign pts[0]  = px;
  assign pts[1]  = py;
  assign pts[2]  = pz;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  // stage 1: nine products
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prod_r[i][0] <= rows[i].cx * pts[0];
        prod_r[i][1] <= rows[i].cy * pts[1];
        prod_r[i][2] <= rows[i].cz * pts[2];
      end
    end
  end

  // stage 2: row sums plus translation
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      loc_nxt[i] = {{(LOC_WIDTH-PW){prod_r[i][0][PW-1]}}, prod_r[i][0]}
                 + {{(LOC_WIDTH-PW){prod_r[i][1][PW-1]}}, prod_r[i][1]}
                 + {{(LOC_WIDTH-PW){prod_r[i][2][PW-1]}}, prod_r[i][2]}
                 + {{(LOC_WIDTH-TW){rows[i].tr[COEF_WIDTH-1]}}, rows[i].tr,
                    {COEF_FRAC{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        loc_r[i] <= loc_nxt[i];
      end
    end
  end

  assign out_valid = v2_r;
  assign lx        = loc_r[0];
  assign ly        = loc_r[1];
  assign lz        = loc_r[2];

endmodule

// ----- rtl/apip_shape.sv -----
// ----------------------------------------------------------------------------
// apip_shape
// inside test of a local point: range check, square and compare stages
// ----------------------------------------------------------------------------
module apip_shape #(
  parameter int LOC_WIDTH = apip_pkg::loc_width(apip_pkg::COORD_WIDTH_DEF)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [LOC_WIDTH-1:0]       lx,
  input  logic signed [LOC_WIDTH-1:0]       ly,
  input  logic signed [LOC_WIDTH-1:0]       lz,
  input  logic [apip_pkg::SHAPE_WIDTH-1:0]  shape_kind,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit
);
  import apip_pkg::*;

  localparam logic signed [LOC_WIDTH-1:0] POS_ONE =
    {{(LOC_WIDTH-LOC_FRAC-1){1'b0}}, 1'b1, {LOC_FRAC{1'b0}}};
  localparam logic signed [LOC_WIDTH-1:0] NEG_ONE = -POS_ONE;
  localparam logic [SQ_WIDTH+1:0] SQ_ONE = {1'b0, 1'b1, {SQ_WIDTH{1'b0}}};

  logic                      v3_r, v4_r, v5_r;
  logic                      en3, en4, en5;
  logic signed [LOC_WIDTH-1:0] abs_x, abs_y, abs_z;
  range_t                    rng_nxt, rng3_r, rng4_r;
  logic [LOC_FRAC-1:0]       ax_r, ay_r, az_r, rr_r;
  logic [SQ_WIDTH-1:0]       sx_r, sy_r, sz_r, sr_r;
  logic [SQ_WIDTH+1:0]       sum3;
  logic [SQ_WIDTH:0]         sum2;
  logic                      inside_nxt;
  logic                      inside_r;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign in_ready = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= in_valid;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  // stage 3: range checks and magnitudes
  assign abs_x = lx[LOC_WIDTH-1] ? -lx : lx;
  assign abs_y = ly[LOC_WIDTH-1] ? -ly : ly;
  assign abs_z = lz[LOC_WIDTH-1] ? -lz : lz;

  always_comb begin
    rng_nxt.ok_x  = (lx > NEG_ONE) && (lx < POS_ONE);
    rng_nxt.ok_y  = (ly > NEG_ONE) && (ly < POS_ONE);
    rng_nxt.ok_z  = (lz > NEG_ONE) && (lz < POS_ONE);
    rng_nxt.y_in  = !ly[LOC_WIDTH-1] && (|ly) && (ly < POS_ONE);
    rng_nxt.z_pos = !lz[LOC_WIDTH-1] && (|lz);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rng3_r <= rng_nxt;
      ax_r   <= abs_x[LOC_FRAC-1:0];
      ay_r   <= abs_y[LOC_FRAC-1:0];
      az_r   <= abs_z[LOC_FRAC-1:0];
      // cone radius one minus y, exact while y lies in the open unit range
      rr_r   <= -ly[LOC_FRAC-1:0];
    end
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (en4) begin
      rng4_r <= rng3_r;
      sx_r   <= ax_r * ax_r;
      sy_r   <= ay_r * ay_r;
      sz_r   <= az_r * az_r;
      sr_r   <= rr_r * rr_r;
    end
  end

  // stage 5: sums, compare and shape select
  assign sum3 = {2'b0, sx_r} + {2'b0, sy_r} + {2'b0, sz_r};
  assign sum2 = {1'b0, sx_r} + {1'b0, sz_r};

  always_comb begin
    case (shape_kind)
      SHAPE_PLANE: begin
        inside_nxt = rng4_r.z_pos;
      end
      SHAPE_BOX: begin
        inside_nxt = rng4_r.ok_x && rng4_r.ok_y && rng4_r.ok_z;
      end
      SHAPE_SPHERE: begin
        inside_nxt = rng4_r.ok_x && rng4_r.ok_y && rng4_r.ok_z && (sum3 < SQ_ONE);
      end
      SHAPE_CYLINDER: begin
        inside_nxt = rng4_r.ok_x && rng4_r.ok_y && rng4_r.ok_z
                   && (sum2 < SQ_ONE[SQ_WIDTH:0]);
      end
      SHAPE_CONE: begin
        inside_nxt = rng4_r.y_in && rng4_r.ok_x && rng4_r.ok_z
                   && (sum2 < {1'b0, sr_r});
      end
      default: begin
        inside_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid = v5_r;
  assign hit       = inside_r;

endmodule

// ----- rtl/affine_point_in_primitive.sv -----
// ----------------------------------------------------------------------------
// affine_point_in_primitive
// clip test of streamed 3d points against an affine-mapped unit primitive
// ----------------------------------------------------------------------------
// Each point transaction is mapped by the configured inverse matrix and tested
// against the selected primitive; one result transaction follows every point.
// The pipeline takes one point per clock while the output is not stalled,
// through five register stages: two stages for the matrix products and row
// sums, then range check, squaring and compare-select. Each stage holds its
// data when the next one is full, so a stalled output backs up point by point.
// Configuration writes are taken in any cycle and must only be made while no
// point is in flight.
module affine_point_in_primitive #(
  parameter int COORD_WIDTH = apip_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_coord, y_coord, z_coord
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // inside_res
  output logic [7:0]                           out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apip_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [apip_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import apip_pkg::*;

  localparam int LW = loc_width(COORD_WIDTH);

  logic [SHAPE_WIDTH-1:0]        shape_r;
  row_t                          row_x_r, row_y_r, row_z_r;
  logic                          mid_valid, mid_ready;
  logic signed [LW-1:0]          lx, ly, lz;
  logic                          hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_SPHERE;
      row_x_r <= ROW_X_RST;
      row_y_r <= ROW_Y_RST;
      row_z_r <= ROW_Z_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_SHAPE: begin
          shape_r <= cfg_data[SHAPE_WIDTH-1:0];
        end
        CFG_ROW_X: begin
          row_x_r <= cfg_data;
        end
        CFG_ROW_Y: begin
          row_y_r <= cfg_data;
        end
        CFG_ROW_Z: begin
          row_z_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  apip_map #(
    .COORD_WIDTH (COORD_WIDTH),
    .LOC_WIDTH   (LW)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .px        (in_tdata[COORD_WIDTH-1:0]),
    .py        (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .pz        (in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .row_x     (row_x_r),
    .row_y     (row_y_r),
    .row_z     (row_z_r),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .lx        (lx),
    .ly        (ly),
    .lz        (lz)
  );

  apip_shape #(
    .LOC_WIDTH (LW)
  ) u_shape (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .lx         (lx),
    .ly         (ly),
    .lz         (lz),
    .shape_kind (shape_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hit        (hit)
  );

  assign out_tdata = {7'b0, hit};

`ifndef SYNTHESIS
  // a drained output never holds back the input side
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a pipeline that is empty of results accepts input
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !mid_valid |-> in_tready)
    else $error("empty pipeline refused a point");
`endif

endmodule
